/* src/four_lane_block_hash64_unit_defines.svh */
// Assertion macros shared by the checker of the block hash unit.
// No dependencies; take in with `include before the module header.
`ifndef FOUR_LANE_BLOCK_HASH64_UNIT_DEFINES_SVH
`define FOUR_LANE_BLOCK_HASH64_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define FBH_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define FBH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/fbh_pkg.sv */
// Types and constants of the four-lane block hash unit.
// No dependencies; imported by the multiplier, datapath and controller.
package fbh_pkg;

  localparam int unsigned WordW  = 64;
  localparam int unsigned NLanes = 4;

  localparam logic [WordW-1:0] K1 = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [WordW-1:0] K2 = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [WordW-1:0] K3 = 64'h94D0_49BB_1331_11EB;

  // per-lane multiplier and restart value of each accumulator
  localparam logic [WordW-1:0] LANE_K    [NLanes] = '{K1, K2, K3, K1};
  localparam logic [WordW-1:0] LANE_INIT [NLanes] = '{K1, K2, K3, K1 ^ K2};

  // log2 of the group size in bytes
  localparam int unsigned GroupShift = 5;

  // operand selection of the lane-0 multiplier
  typedef enum logic [1:0] {
    SRC_LANE    = 2'd0,  // (acc0 ^ word0) * K1
    SRC_ACC0_K1 = 2'd1,  // acc0 * K1
    SRC_H_K2    = 2'd2,  // h * K2
    SRC_H_K3    = 2'd3   // h * K3
  } mul_src_e;

  // how the running fold value takes the lane-0 product
  typedef enum logic [2:0] {
    H_XOR_ACC1     = 3'd0,
    H_XOR_ACC2     = 3'd1,
    H_XOR_ACC3_LEN = 3'd2,  // also applies the first shift-xor of the finalizer
    H_MIX29        = 3'd3,
    H_MIX32        = 3'd4
  } h_upd_e;

  localparam int unsigned FoldSteps = 5;
  localparam int unsigned StepW     = $clog2(FoldSteps);
  localparam logic [StepW-1:0] FoldLast = StepW'(FoldSteps - 1);

  localparam mul_src_e FOLD_SRC [FoldSteps] =
    '{SRC_ACC0_K1, SRC_H_K2, SRC_H_K3, SRC_H_K2, SRC_H_K3};
  localparam h_upd_e FOLD_UPD [FoldSteps] =
    '{H_XOR_ACC1, H_XOR_ACC2, H_XOR_ACC3_LEN, H_MIX29, H_MIX32};

  typedef struct packed {
    logic     issue_lanes;  // start all four lane multiplies
    logic     issue_fold;   // start a fold multiply on lane 0
    mul_src_e src;
    logic     absorb;       // take lane products, count the group
    logic     h_load;
    h_upd_e   h_sel;
    logic     restart;      // restore accumulators, clear count
    logic     out_load;
  } cmd_t;

endpackage

/* src/fbh_mul64.sv */
// 64x64 multiplier, product kept modulo 2^64.
// Three 32x32 partial products are registered; the sum follows them.
module fbh_mul64 import fbh_pkg::*; (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [WordW-1:0] a_i,
  input  logic [WordW-1:0] b_i,
  output logic [WordW-1:0] p_o
);

  logic [63:0] ll_d, ll_q;
  logic [31:0] lh_d, lh_q;
  logic [31:0] hl_d, hl_q;

  assign ll_d = a_i[31:0] * b_i[31:0];
  assign lh_d = a_i[31:0] * b_i[63:32];
  assign hl_d = a_i[63:32] * b_i[31:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= ll_d;
      lh_q <= lh_d;
      hl_q <= hl_d;
    end
  end

  assign p_o = ll_q + {lh_q + hl_q, 32'b0};

endmodule

/* src/fbh_datapath.sv */
// Datapath of the block hash: lane accumulators, group counter, fold register
// and result register. Depends on fbh_pkg and fbh_mul64.
module fbh_datapath import fbh_pkg::*; #(
  parameter int unsigned MAX_GROUPS = 128
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cmd_t                         cmd_i,
  input  logic [NLanes-1:0][WordW-1:0] words_i,
  output logic [WordW-1:0]             hash_o,
  output logic                         too_long_o
);

  localparam int unsigned CntW = $clog2(MAX_GROUPS + 1);

  logic [NLanes-1:0][WordW-1:0] acc_q, acc_d;
  logic [NLanes-1:0][WordW-1:0] prod;
  logic [CntW-1:0]              cnt_q, cnt_d;
  logic                         ovf_q, ovf_d;
  logic [WordW-1:0]             h_q, h_d;
  logic [WordW-1:0]             hash_q;
  logic                         too_long_q;
  logic [WordW-1:0]             a0, b0, t3, len;

  // lane 0 is shared with the fold and finalizer
  always_comb begin
    unique case (cmd_i.src)
      SRC_LANE: begin
        a0 = acc_q[0] ^ words_i[0];
        b0 = K1;
      end
      SRC_ACC0_K1: begin
        a0 = acc_q[0];
        b0 = K1;
      end
      SRC_H_K2: begin
        a0 = h_q;
        b0 = K2;
      end
      SRC_H_K3: begin
        a0 = h_q;
        b0 = K3;
      end
    endcase
  end

  fbh_mul64 u_mul0 (
    .clk_i (clk_i),
    .en_i  (cmd_i.issue_lanes | cmd_i.issue_fold),
    .a_i   (a0),
    .b_i   (b0),
    .p_o   (prod[0])
  );

  for (genvar i = 1; i < NLanes; i++) begin : g_lane
    fbh_mul64 u_mul (
      .clk_i (clk_i),
      .en_i  (cmd_i.issue_lanes),
      .a_i   (acc_q[i] ^ words_i[i]),
      .b_i   (LANE_K[i]),
      .p_o   (prod[i])
    );
  end

  always_comb begin
    acc_d = acc_q;
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (cmd_i.restart) begin
      for (int i = 0; i < NLanes; i++) acc_d[i] = LANE_INIT[i];
      cnt_d = '0;
      ovf_d = 1'b0;
    end else if (cmd_i.absorb) begin
      acc_d = prod;
      // saturate the count, flag the overrun
      if (cnt_q < CntW'(MAX_GROUPS)) cnt_d = cnt_q + 1'b1;
      else                           ovf_d = 1'b1;
    end
  end

  assign len = WordW'(cnt_q) << GroupShift;
  assign t3  = prod[0] ^ acc_q[3] ^ len;

  always_comb begin
    unique case (cmd_i.h_sel)
      H_XOR_ACC1:     h_d = prod[0] ^ acc_q[1];
      H_XOR_ACC2:     h_d = prod[0] ^ acc_q[2];
      H_XOR_ACC3_LEN: h_d = t3 ^ (t3 >> 33);
      H_MIX29:        h_d = prod[0] ^ (prod[0] >> 29);
      H_MIX32:        h_d = prod[0] ^ (prod[0] >> 32);
      default:        h_d = h_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NLanes; i++) acc_q[i] <= LANE_INIT[i];
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.h_load) h_q <= h_d;
    if (cmd_i.out_load) begin
      hash_q     <= h_q;
      too_long_q <= ovf_q;
    end
  end

  assign hash_o     = hash_q;
  assign too_long_o = too_long_q;

endmodule

/* src/fbh_ctrl.sv */
// Controller of the block hash: sequences absorb, fold and finalize steps and
// owns the stream handshakes. Depends on fbh_pkg.
module fbh_ctrl import fbh_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_valid_i,
  input  logic s_last_i,
  output logic s_ready_o,
  input  logic m_ready_i,
  output logic m_valid_o,
  output cmd_t cmd_o
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_ABSORB = 5'b00010,
    S_ISSUE  = 5'b00100,
    S_DONE   = 5'b01000,
    S_FIN    = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic             last_q, last_d;
  logic             out_valid_q, out_valid_d;

  always_comb begin
    state_d   = state_q;
    step_d    = step_q;
    last_d    = last_q;
    s_ready_o = 1'b0;
    cmd_o     = '0;
    cmd_o.src = SRC_LANE;
    unique case (state_q)
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.issue_lanes = 1'b1;
          last_d            = s_last_i;
          state_d           = S_ABSORB;
        end
      end
      S_ABSORB: begin
        cmd_o.absorb = 1'b1;
        step_d       = '0;
        state_d      = last_q ? S_ISSUE : S_IDLE;
      end
      S_ISSUE: begin
        cmd_o.issue_fold = 1'b1;
        cmd_o.src        = FOLD_SRC[step_q];
        state_d          = S_DONE;
      end
      S_DONE: begin
        cmd_o.h_load = 1'b1;
        cmd_o.h_sel  = FOLD_UPD[step_q];
        if (step_q == FoldLast) begin
          state_d = S_FIN;
        end else begin
          step_d  = step_q + 1'b1;
          state_d = S_ISSUE;
        end
      end
      S_FIN: begin
        // hold the hash until the output register is free
        if (!out_valid_q || m_ready_i) begin
          cmd_o.out_load = 1'b1;
          cmd_o.restart  = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.out_load | (out_valid_q & ~m_ready_i);
  assign m_valid_o   = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* src/four_lane_block_hash64_unit.sv */
// Four-lane multiply-xor block hash with a 64-bit finalizer.
// Input stream: one beat is one 32-byte group, four little-endian 64-bit
// words; tlast marks the final group of a block. Output stream: one beat per
// block with the 64-bit hash in tdata and the overrun flag in tuser.
// A group that is not last: the accept cycle starts the four lane multiplies
// (three 32x32 partial products each), the next cycle writes the
// accumulators, and the input is ready again after that.
// A last group adds a fold and finalizer of five dependent multiplies on the
// lane-0 multiplier, each an issue state then a done state; the hash appears
// and the input is ready again together, once the output register is free.
// Blocks longer than MAX_GROUPS groups still hash every group; the length
// term saturates at MAX_GROUPS*32 and tuser reports the overrun.
// Reset restores the initial accumulators and clears count and output valid.
// A stalled output beat holds; the next block is accepted meanwhile and its
// result waits in the finalizer until the output register is free.
// Depends on fbh_pkg, fbh_ctrl, fbh_datapath and fbh_mul64.
module four_lane_block_hash64_unit import fbh_pkg::*; #(
  parameter int unsigned MAX_GROUPS = 128
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // lane0_word [63:0], lane1_word [127:64], lane2_word [191:128],
  // lane3_word [255:192]
  input  logic [255:0] s_axis_tdata_i,
  input  logic         s_axis_tlast_i,   // last_group
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [63:0]  m_axis_tdata_o,   // hash_value [63:0]
  output logic         m_axis_tuser_o    // too_long [0]
);

  cmd_t                         cmd;
  logic [NLanes-1:0][WordW-1:0] words;

  assign words = s_axis_tdata_i;

  fbh_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_last_i  (s_axis_tlast_i),
    .s_ready_o (s_axis_tready_o),
    .m_ready_i (m_axis_tready_i),
    .m_valid_o (m_axis_tvalid_o),
    .cmd_o     (cmd)
  );

  fbh_datapath #(
    .MAX_GROUPS (MAX_GROUPS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .words_i    (words),
    .hash_o     (m_axis_tdata_o),
    .too_long_o (m_axis_tuser_o)
  );

endmodule

/* src/fbh_checker.sv */
// Port-level checks of the block hash unit, bound to the top level.
// Depends on the assertion macros in four_lane_block_hash64_unit_defines.svh.
`include "four_lane_block_hash64_unit_defines.svh"

module fbh_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         s_axis_tvalid_i,
  input logic         s_axis_tready_o,
  input logic         s_axis_tlast_i,
  input logic         m_axis_tvalid_o,
  input logic         m_axis_tready_i,
  input logic [63:0]  m_axis_tdata_o,
  input logic         m_axis_tuser_o
);

  logic s_beat;

  assign s_beat = s_axis_tvalid_i && s_axis_tready_o;

  // a stalled result beat holds
  `FBH_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i,
    m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o),
    "output beat changed while stalled")

  // a group that is not last never starts a result
  `FBH_ASSERT_NEXT(a_no_early_out, clk_i, rst_ni, s_beat && !s_axis_tlast_i,
    !$rose(m_axis_tvalid_o), "result after a non-last group")

  // the fold keeps the input closed
  `FBH_ASSERT_NEXT(a_busy_on_last, clk_i, rst_ni, s_beat && s_axis_tlast_i,
    !s_axis_tready_o ##1 !s_axis_tready_o, "input reopened during fold")

  // a result comes out of the finalizer, never while the input was open
  `FBH_ASSERT_IMPL(a_out_from_fin, clk_i, rst_ni, $rose(m_axis_tvalid_o),
    $past(!s_axis_tready_o), "result raised while input was ready")

endmodule

bind four_lane_block_hash64_unit fbh_checker u_fbh_checker (.*);

/* test/tb_four_lane_block_hash64_unit.sv */
// Self-checking testbench of four_lane_block_hash64_unit: random bursts of
// 32-byte groups, a behavioral hash predictor and a scoreboard of digests.
// Depends on fbh_pkg and the RTL of the block hash unit.
module tb_four_lane_block_hash64_unit;
  import fbh_pkg::K1;
  import fbh_pkg::K2;
  import fbh_pkg::K3;

  localparam int unsigned BLOCK_GROUPS_MAX = 128;
  localparam int unsigned ITEM_TARGET      = 1000;
  localparam int unsigned CYCLE_LIMIT      = 400000;
  localparam int unsigned DRAIN_CYCLES     = 40;

  typedef struct packed {
    logic [255:0] words;
    logic         last;
  } group_t;

  typedef struct packed {
    logic [63:0] hash;
    logic        too_long;
  } digest_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [255:0] s_tdata = '0;
  logic         s_tlast = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [63:0]  m_tdata;
  logic         m_tuser;

  group_t  group_fifo[$];
  digest_t digest_expect[$];
  group_t  next_group;
  digest_t head_digest;

  // predictor state
  logic [63:0] lane_acc[4];
  int unsigned grp_count;
  logic        overrun;

  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  logic [31:0] ready_cnt = '0;
  logic [1:0]  stall_mode = 2'd0;
  int unsigned cycle_cnt = 0;
  int unsigned mismatches = 0;

  four_lane_block_hash64_unit #(
    .MAX_GROUPS(BLOCK_GROUPS_MAX)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tlast_i (s_tlast),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  task automatic restart_hash();
    lane_acc[0] = K1;
    lane_acc[1] = K2;
    lane_acc[2] = K3;
    lane_acc[3] = K1 ^ K2;
    grp_count   = 0;
    overrun     = 1'b0;
  endtask

  // Absorb one accepted group; on the last group fold, finalize and queue the digest.
  task automatic hash_absorb(input logic [255:0] words, input logic last);
    logic [63:0] h;
    digest_t     d;
    lane_acc[0] = (lane_acc[0] ^ words[63:0])    * K1;
    lane_acc[1] = (lane_acc[1] ^ words[127:64])  * K2;
    lane_acc[2] = (lane_acc[2] ^ words[191:128]) * K3;
    lane_acc[3] = (lane_acc[3] ^ words[255:192]) * K1;
    if (grp_count < BLOCK_GROUPS_MAX) grp_count++;
    else overrun = 1'b1;
    if (last) begin
      h = lane_acc[0];
      h = (h * K1) ^ lane_acc[1];
      h = (h * K2) ^ lane_acc[2];
      h = (h * K3) ^ lane_acc[3];
      h ^= 64'(grp_count) << 5;
      h ^= h >> 33;
      h *= K2;
      h ^= h >> 29;
      h *= K3;
      h ^= h >> 32;
      d.hash     = h;
      d.too_long = overrun;
      digest_expect.push_back(d);
      restart_hash();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH at cycle %0d, %s: got %h, expected %h", cycle_cnt, what, got, want);
    mismatches++;
  endtask

  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 11))
      0:       return '0;
      1:       return '1;
      2:       return 64'd1 << $urandom_range(0, 63);
      3:       return ~(64'd1 << $urandom_range(0, 63));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic add_group(input logic [255:0] words, input logic last);
    group_t g;
    g.words = words;
    g.last  = last;
    group_fifo.push_back(g);
  endtask

  task automatic add_block(input int unsigned n_groups);
    for (int unsigned i = 0; i < n_groups; i++) begin
      add_group({rand_word(), rand_word(), rand_word(), rand_word()}, i == n_groups - 1);
    end
  endtask

  // Mostly short blocks, some medium, a few around the saturation point.
  function automatic int unsigned pick_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 80) return $urandom_range(1, 6);
    if (r < 95) return $urandom_range(7, 40);
    return $urandom_range(BLOCK_GROUPS_MAX - 8, BLOCK_GROUPS_MAX + 8);
  endfunction

  // Sender: bursts of beats separated by random gaps; hold a beat until taken.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_tvalid   <= 1'b0;
      s_tdata    <= '0;
      s_tlast    <= 1'b0;
      burst_left <= 1;
      gap_left   <= 0;
    end else begin
      if (s_tvalid && s_tready) hash_absorb(s_tdata, s_tlast);
      if (!s_tvalid || s_tready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          s_tvalid <= 1'b0;
        end else if (group_fifo.size() != 0) begin
          next_group = group_fifo.pop_front();
          s_tdata  <= next_group.words;
          s_tlast  <= next_group.last;
          s_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: check each digest beat, then stall on a randomly picked mode.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (digest_expect.size() == 0) begin
          report_mismatch("digest beat with no block pending", m_tdata, '0);
        end else begin
          head_digest = digest_expect.pop_front();
          if (m_tdata !== head_digest.hash)
            report_mismatch("hash_value", m_tdata, head_digest.hash);
          if (m_tuser !== head_digest.too_long)
            report_mismatch("too_long", 64'(m_tuser), 64'(head_digest.too_long));
        end
      end
      ready_cnt = ready_cnt + 1;
      if (ready_cnt % 300 == 0) stall_mode = 2'($urandom_range(0, 3));
      case (stall_mode)
        2'd0:    m_tready <= 1'b1;
        2'd1:    m_tready <= 1'($urandom_range(0, 1));
        2'd2:    m_tready <= (ready_cnt[2:0] == 3'd0);
        default: m_tready <= ready_cnt[4];
      endcase
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    restart_hash();

    // single-group blocks at the word extremes
    add_group('0, 1'b1);
    add_group('1, 1'b1);
    add_group({64'h8000_0000_0000_0000, 64'h1, 64'h8000_0000_0000_0000, 64'h1}, 1'b1);
    // two- and three-group blocks with fixed patterns
    add_group({64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
               64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555}, 1'b0);
    add_group({64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
               64'hFEDC_BA98_7654_3210, 64'h0123_4567_89AB_CDEF}, 1'b1);
    add_group('1, 1'b0);
    add_group('0, 1'b0);
    add_group({K1, K2, K3, K1 ^ K2}, 1'b1);
    add_block(4);
    add_block(1);

    // exactly the group limit, then one past it so the count saturates and the overrun is flagged
    add_block(BLOCK_GROUPS_MAX);
    add_block(BLOCK_GROUPS_MAX + 1);
    while (group_fifo.size() < ITEM_TARGET) add_block(pick_len());

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (group_fifo.size() != 0 || s_tvalid) @(posedge clk_i);
    while (digest_expect.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
